// ----- hdl/gaes_pkg.sv -----
package gaes_pkg;

   localparam int VERTEX_COUNT = 1024;
   localparam int SLOT_COUNT   = 8192;
   localparam int VTX_W        = $clog2(VERTEX_COUNT);
   localparam int SLOT_W       = $clog2(SLOT_COUNT);
   localparam int DEG_W        = 14;

   typedef enum logic [1:0] {
      CMD_SET    = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      KIND_SET,
      KIND_TAB,
      KIND_INC,
      KIND_SAVED,
      KIND_DEC
   } kind_type;

   typedef struct packed {
      cmd_type     command;
      logic [9:0]  source_vertex;
      logic [9:0]  target_vertex;
      logic [12:0] out_list_base;
      logic [12:0] in_list_base;
      logic [13:0] out_list_capacity;
      logic [13:0] in_list_capacity;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [13:0] source_out_degree;
      logic [13:0] target_in_degree;
   } rsp_type;

   typedef struct packed {
      logic       latch;
      logic       clear_wr;
      logic       save_deg;
      logic       set_wr;
      logic       ins_wr;
      logic       idx_zero;
      logic       idx_inc;
      logic       idx_opos;
      logic       idx_ipos;
      logic       save_opos;
      logic       save_ipos;
      logic       rd_next;
      logic       o_shift_wr;
      logic       i_shift_wr;
      logic       odeg_dec;
      logic       ideg_dec;
      logic       rsp_fire;
      status_type rsp_status;
      kind_type   rsp_kind;
   } ctrl_type;

   typedef struct packed {
      cmd_type command;
      logic    full;
      logic    clr_last;
      logic    o_end;
      logic    i_end;
      logic    o_last;
      logic    i_last;
      logic    o_match;
      logic    i_match;
   } stat_type;

   function automatic logic [SLOT_W-1:0] slot_at(input logic [SLOT_W-1:0] base,
                                                 input logic [DEG_W:0] ofs);
      logic [DEG_W+1:0] sum;
      sum = {{(DEG_W+2-SLOT_W){1'b0}}, base} + {1'b0, ofs};
      return sum[SLOT_W-1:0];
   endfunction

   function automatic logic [DEG_W-1:0] sat_cap(input logic [DEG_W-1:0] cap);
      logic [DEG_W-1:0] lim;
      lim = DEG_W'(SLOT_COUNT);
      return (cap > lim) ? lim : cap;
   endfunction

endpackage

// ----- hdl/gapped_adjacency_edge_store.sv -----
// Directed graph store with gapped out-lists and in-lists per vertex.
// Command channel: drive req_item and raise start; the command transfers at
// the rising edge where start is high and busy is low. busy stays high until
// the command is complete.
// Result channel: rsp_valid pulses for one cycle with rsp_item (status and
// the two degrees after the command). The receiver cannot stall it.
// Set, insert and the unused code answer from the decide state. Delete walks
// the out-list then the in-list, reading then checking each entry examined,
// then shifts each list down, one read and one write per moved entry. Every
// step is one read of the single read port of a neighbour store, so one item
// is in flight at a time; a new command may transfer in the cycle rsp_valid is
// high.
// After reset the degree tables are cleared, one vertex a cycle, for all
// VERTEX_COUNT (1024) vertices with busy high; no command transfers meanwhile.
module gapped_adjacency_edge_store (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gaes_pkg::req_type req_item,
   output logic              rsp_valid,
   output gaes_pkg::rsp_type rsp_item
);

   gaes_pkg::ctrl_type ctrl;
   gaes_pkg::stat_type stat;

   gaes_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .ctrl  (ctrl)
   );

   gaes_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .ctrl      (ctrl),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   a_single_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy low after a command transfer");

   a_no_result_while_clear: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear_wr |=> !rsp_valid) else $error("result during degree clearing");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.status == gaes_pkg::ST_OK ||
                     rsp_item.status == gaes_pkg::ST_NOT_FOUND ||
                     rsp_item.status == gaes_pkg::ST_FULL))
      else $error("result with unused status code");

endmodule

// ----- hdl/gaes_datapath.sv -----
module gaes_datapath (
   input  logic              clock,
   input  logic              reset,
   input  gaes_pkg::req_type req_item,
   input  gaes_pkg::ctrl_type ctrl,
   output gaes_pkg::stat_type stat,
   output logic              rsp_valid,
   output gaes_pkg::rsp_type rsp_item
);

   localparam int VW = gaes_pkg::VTX_W;
   localparam int SW = gaes_pkg::SLOT_W;
   localparam int DW = gaes_pkg::DEG_W;
   localparam int VN = gaes_pkg::VERTEX_COUNT;
   localparam int SN = gaes_pkg::SLOT_COUNT;

   logic [SW-1:0] obase_mem [VN];
   logic [SW-1:0] ibase_mem [VN];
   logic [DW-1:0] ocap_mem  [VN];
   logic [DW-1:0] icap_mem  [VN];
   logic [DW-1:0] odeg_mem  [VN];
   logic [DW-1:0] ideg_mem  [VN];
   logic [VW-1:0] ostore_mem [SN];
   logic [VW-1:0] istore_mem [SN];

   gaes_pkg::req_type req_ff;
   logic [VW-1:0] clr_ff, clr_in;
   logic [DW-1:0] idx_ff, idx_in, opos_ff, ipos_ff, sdeg_ff, ddeg_ff;
   logic [SW-1:0] obase_ff, ibase_ff;
   logic [DW-1:0] ocap_ff, icap_ff, odeg_ff, ideg_ff;
   logic [VW-1:0] odata_ff, idata_ff;
   logic          rsp_valid_ff;
   gaes_pkg::rsp_type rsp_ff, rsp_in;

   logic [VW-1:0] src, dst;
   logic [DW:0]   idx_ext, rd_ofs;
   logic [SW-1:0] o_raddr, i_raddr, o_waddr, i_waddr;
   logic [VW-1:0] o_wdata, i_wdata;
   logic          o_we, i_we, od_we, id_we;
   logic [VW-1:0] od_addr, id_addr;
   logic [DW-1:0] od_wdata, id_wdata;

   assign src     = req_ff.source_vertex[VW-1:0];
   assign dst     = req_ff.target_vertex[VW-1:0];
   assign idx_ext = {1'b0, idx_ff};
   assign rd_ofs  = idx_ext + {{DW{1'b0}}, ctrl.rd_next};
   assign o_raddr = gaes_pkg::slot_at(obase_ff, rd_ofs);
   assign i_raddr = gaes_pkg::slot_at(ibase_ff, rd_ofs);

   always_comb begin
      o_we    = 1'b0;
      i_we    = 1'b0;
      o_waddr = gaes_pkg::slot_at(obase_ff, idx_ext);
      i_waddr = gaes_pkg::slot_at(ibase_ff, idx_ext);
      o_wdata = odata_ff;
      i_wdata = idata_ff;
      if (ctrl.ins_wr) begin
         o_we    = 1'b1;
         i_we    = 1'b1;
         o_waddr = gaes_pkg::slot_at(obase_ff, {1'b0, odeg_ff});
         i_waddr = gaes_pkg::slot_at(ibase_ff, {1'b0, ideg_ff});
         o_wdata = dst;
         i_wdata = src;
      end else begin
         o_we = ctrl.o_shift_wr;
         i_we = ctrl.i_shift_wr;
      end
   end

   always_comb begin
      od_we    = ctrl.clear_wr | ctrl.set_wr | ctrl.ins_wr | ctrl.odeg_dec;
      id_we    = ctrl.clear_wr | ctrl.set_wr | ctrl.ins_wr | ctrl.ideg_dec;
      od_addr  = ctrl.clear_wr ? clr_ff : src;
      id_addr  = ctrl.clear_wr ? clr_ff : (ctrl.set_wr ? src : dst);
      od_wdata = '0;
      id_wdata = '0;
      if (ctrl.ins_wr) begin
         od_wdata = odeg_ff + DW'(1);
         id_wdata = ideg_ff + DW'(1);
      end else begin
         if (ctrl.odeg_dec) od_wdata = sdeg_ff - DW'(1);
         if (ctrl.ideg_dec) id_wdata = ddeg_ff - DW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.set_wr) begin
         obase_mem[src] <= req_ff.out_list_base[SW-1:0];
         ibase_mem[src] <= req_ff.in_list_base[SW-1:0];
         ocap_mem[src]  <= gaes_pkg::sat_cap(req_ff.out_list_capacity);
         icap_mem[src]  <= gaes_pkg::sat_cap(req_ff.in_list_capacity);
      end
      if (od_we) odeg_mem[od_addr] <= od_wdata;
      if (id_we) ideg_mem[id_addr] <= id_wdata;
      obase_ff <= obase_mem[src];
      ocap_ff  <= ocap_mem[src];
      odeg_ff  <= odeg_mem[src];
      ibase_ff <= ibase_mem[dst];
      icap_ff  <= icap_mem[dst];
      ideg_ff  <= ideg_mem[dst];
   end

   always_ff @(posedge clock) begin
      if (o_we) ostore_mem[o_waddr] <= o_wdata;
      if (i_we) istore_mem[i_waddr] <= i_wdata;
      odata_ff <= ostore_mem[o_raddr];
      idata_ff <= istore_mem[i_raddr];
   end

   always_comb begin
      idx_in = idx_ff;
      if (ctrl.idx_zero)      idx_in = '0;
      else if (ctrl.idx_opos) idx_in = opos_ff;
      else if (ctrl.idx_ipos) idx_in = ipos_ff;
      else if (ctrl.idx_inc)  idx_in = idx_ff + DW'(1);
      clr_in = ctrl.clear_wr ? clr_ff + VW'(1) : clr_ff;
   end

   always_comb begin
      rsp_in = rsp_ff;
      rsp_in.status = ctrl.rsp_status;
      case (ctrl.rsp_kind)
         gaes_pkg::KIND_SET: begin
            rsp_in.source_out_degree = '0;
            rsp_in.target_in_degree  = '0;
         end
         gaes_pkg::KIND_TAB: begin
            rsp_in.source_out_degree = odeg_ff;
            rsp_in.target_in_degree  = ideg_ff;
         end
         gaes_pkg::KIND_INC: begin
            rsp_in.source_out_degree = odeg_ff + DW'(1);
            rsp_in.target_in_degree  = ideg_ff + DW'(1);
         end
         gaes_pkg::KIND_DEC: begin
            rsp_in.source_out_degree = sdeg_ff - DW'(1);
            rsp_in.target_in_degree  = ddeg_ff - DW'(1);
         end
         default: begin
            rsp_in.source_out_degree = sdeg_ff;
            rsp_in.target_in_degree  = ddeg_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         rsp_valid_ff <= ctrl.rsp_fire;
      end
      if (ctrl.latch) req_ff <= req_item;
      idx_ff <= idx_in;
      if (ctrl.save_opos) opos_ff <= idx_ff;
      if (ctrl.save_ipos) ipos_ff <= idx_ff;
      if (ctrl.save_deg) begin
         sdeg_ff <= odeg_ff;
         ddeg_ff <= ideg_ff;
      end
      if (ctrl.rsp_fire) rsp_ff <= rsp_in;
   end

   always_comb begin
      stat.command  = req_ff.command;
      stat.full     = (odeg_ff >= ocap_ff) || (ideg_ff >= icap_ff);
      stat.clr_last = &clr_ff;
      stat.o_end    = idx_ff >= sdeg_ff;
      stat.i_end    = idx_ff >= ddeg_ff;
      stat.o_last   = (idx_ext + (DW+1)'(1)) >= {1'b0, sdeg_ff};
      stat.i_last   = (idx_ext + (DW+1)'(1)) >= {1'b0, ddeg_ff};
      stat.o_match  = odata_ff == dst;
      stat.i_match  = idata_ff == src;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ----- hdl/gaes_ctrl.sv -----
module gaes_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  gaes_pkg::stat_type stat,
   output logic               busy,
   output gaes_pkg::ctrl_type ctrl
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_WAIT, S_DECIDE,
      S_OS_RD, S_OS_CHK, S_IS_RD, S_IS_CHK,
      S_OF_RD, S_OF_WR, S_IF_RD, S_IF_WR
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      ctrl.rsp_status = gaes_pkg::ST_OK;
      ctrl.rsp_kind   = gaes_pkg::KIND_TAB;
      case (state_ff)
         S_CLEAR: begin
            ctrl.clear_wr = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               ctrl.latch = 1'b1;
               state_in   = S_WAIT;
            end
         end
         S_WAIT: state_in = S_DECIDE;
         S_DECIDE: begin
            state_in = S_IDLE;
            case (stat.command)
               gaes_pkg::CMD_SET: begin
                  ctrl.set_wr   = 1'b1;
                  ctrl.rsp_fire = 1'b1;
                  ctrl.rsp_kind = gaes_pkg::KIND_SET;
               end
               gaes_pkg::CMD_INSERT: begin
                  ctrl.rsp_fire = 1'b1;
                  if (stat.full) begin
                     ctrl.rsp_status = gaes_pkg::ST_FULL;
                  end else begin
                     ctrl.ins_wr   = 1'b1;
                     ctrl.rsp_kind = gaes_pkg::KIND_INC;
                  end
               end
               gaes_pkg::CMD_DELETE: begin
                  ctrl.save_deg = 1'b1;
                  ctrl.idx_zero = 1'b1;
                  state_in      = S_OS_RD;
               end
               default: ctrl.rsp_fire = 1'b1;
            endcase
         end
         S_OS_RD, S_IS_RD: begin
            if ((state_ff == S_OS_RD) ? stat.o_end : stat.i_end) begin
               ctrl.rsp_fire   = 1'b1;
               ctrl.rsp_status = gaes_pkg::ST_NOT_FOUND;
               ctrl.rsp_kind   = gaes_pkg::KIND_SAVED;
               state_in        = S_IDLE;
            end else begin
               state_in = (state_ff == S_OS_RD) ? S_OS_CHK : S_IS_CHK;
            end
         end
         S_OS_CHK: begin
            if (stat.o_match) begin
               ctrl.save_opos = 1'b1;
               ctrl.idx_zero  = 1'b1;
               state_in       = S_IS_RD;
            end else begin
               ctrl.idx_inc = 1'b1;
               state_in     = S_OS_RD;
            end
         end
         S_IS_CHK: begin
            if (stat.i_match) begin
               ctrl.save_ipos = 1'b1;
               ctrl.idx_opos  = 1'b1;
               state_in       = S_OF_RD;
            end else begin
               ctrl.idx_inc = 1'b1;
               state_in     = S_IS_RD;
            end
         end
         S_OF_RD: begin
            ctrl.rd_next = 1'b1;
            if (stat.o_last) begin
               ctrl.odeg_dec = 1'b1;
               ctrl.idx_ipos = 1'b1;
               state_in      = S_IF_RD;
            end else begin
               state_in = S_OF_WR;
            end
         end
         S_OF_WR: begin
            ctrl.o_shift_wr = 1'b1;
            ctrl.idx_inc    = 1'b1;
            state_in        = S_OF_RD;
         end
         S_IF_RD: begin
            ctrl.rd_next = 1'b1;
            if (stat.i_last) begin
               ctrl.ideg_dec = 1'b1;
               ctrl.rsp_fire = 1'b1;
               ctrl.rsp_kind = gaes_pkg::KIND_DEC;
               state_in      = S_IDLE;
            end else begin
               state_in = S_IF_WR;
            end
         end
         S_IF_WR: begin
            ctrl.i_shift_wr = 1'b1;
            ctrl.idx_inc    = 1'b1;
            state_in        = S_IF_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != S_IDLE;

endmodule

// ----- bench/gapped_adjacency_edge_store_test.sv -----
module gapped_adjacency_edge_store_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 750;
   localparam int CYCLE_LIMIT  = 5000000;
   localparam int POOL_SIZE    = 8;
   localparam int VN           = gaes_pkg::VERTEX_COUNT;
   localparam int SN           = gaes_pkg::SLOT_COUNT;

   typedef struct {
      gaes_pkg::req_type cmd;
      bit                typed;
      gaes_pkg::rsp_type want;
   } table_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   gaes_pkg::req_type req_item = '0;
   logic              rsp_valid;
   gaes_pkg::rsp_type rsp_item;

   int out_base [VN];
   int in_base  [VN];
   int out_cap  [VN];
   int in_cap   [VN];
   int out_deg  [VN];
   int in_deg   [VN];
   int out_slots[SN];
   int in_slots [SN];
   bit laid_out [VN];

   gaes_pkg::rsp_type pending_rsp[$];
   table_row_type     rows[$];
   int                pool[POOL_SIZE];
   int                errors = 0;
   int                cycles = 0;
   int                burst_left = 0;

   gapped_adjacency_edge_store i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycles, msg);
      errors++;
   endtask

   function automatic int find_pos(input bit outs, input int base, input int deg,
                                   input int key);
      int i;
      for (i = 0; i < deg; i++) begin
         if ((outs ? out_slots[(base + i) % SN]
                   : in_slots[(base + i) % SN]) == key)
            return i;
      end
      return deg;
   endfunction

   function automatic gaes_pkg::rsp_type apply_command(input gaes_pkg::req_type r);
      int                s, d, sd, dd, op, ip, i;
      gaes_pkg::rsp_type y;
      s = int'(r.source_vertex);
      d = int'(r.target_vertex);
      y = '0;
      y.status = gaes_pkg::ST_OK;
      case (r.command)
         gaes_pkg::CMD_SET: begin
            out_base[s] = int'(r.out_list_base);
            in_base[s]  = int'(r.in_list_base);
            out_cap[s]  = (int'(r.out_list_capacity) > SN) ? SN : int'(r.out_list_capacity);
            in_cap[s]   = (int'(r.in_list_capacity) > SN) ? SN : int'(r.in_list_capacity);
            out_deg[s]  = 0;
            in_deg[s]   = 0;
            laid_out[s] = 1'b1;
            return y;
         end
         gaes_pkg::CMD_INSERT: begin
            sd = out_deg[s];
            dd = in_deg[d];
            if (sd >= out_cap[s] || dd >= in_cap[d]) begin
               y.status = gaes_pkg::ST_FULL;
            end else begin
               out_slots[(out_base[s] + sd) % SN] = d;
               out_deg[s] = sd + 1;
               dd = in_deg[d];
               in_slots[(in_base[d] + dd) % SN] = s;
               in_deg[d] = dd + 1;
            end
         end
         gaes_pkg::CMD_DELETE: begin
            sd = out_deg[s];
            dd = in_deg[d];
            op = find_pos(1'b1, out_base[s], sd, d);
            ip = find_pos(1'b0, in_base[d], dd, s);
            if (op >= sd || ip >= dd) begin
               y.status = gaes_pkg::ST_NOT_FOUND;
            end else begin
               for (i = op; i + 1 < sd; i++)
                  out_slots[(out_base[s] + i) % SN] =
                     out_slots[(out_base[s] + i + 1) % SN];
               out_deg[s] = sd - 1;
               for (i = ip; i + 1 < dd; i++)
                  in_slots[(in_base[d] + i) % SN] =
                     in_slots[(in_base[d] + i + 1) % SN];
               in_deg[d] = dd - 1;
            end
         end
         default: ;
      endcase
      y.source_out_degree = 14'(out_deg[s]);
      y.target_in_degree  = 14'(in_deg[d]);
      return y;
   endfunction

   task automatic add_row(input gaes_pkg::cmd_type c, input int s, input int d,
                          input int ob, input int ib, input int oc, input int ic,
                          input bit typed, input gaes_pkg::status_type st,
                          input int sdeg, input int ddeg);
      table_row_type row;
      row.cmd.command            = c;
      row.cmd.source_vertex      = 10'(s);
      row.cmd.target_vertex      = 10'(d);
      row.cmd.out_list_base      = 13'(ob);
      row.cmd.in_list_base       = 13'(ib);
      row.cmd.out_list_capacity  = 14'(oc);
      row.cmd.in_list_capacity   = 14'(ic);
      row.typed                  = typed;
      row.want.status            = st;
      row.want.source_out_degree = 14'(sdeg);
      row.want.target_in_degree  = 14'(ddeg);
      rows.insert(rows.size(), row);
   endtask

   task automatic send(input gaes_pkg::req_type r, input bit typed,
                       input gaes_pkg::rsp_type want);
      gaes_pkg::rsp_type y;
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      y = apply_command(r);
      pending_rsp.insert(pending_rsp.size(), typed ? want : y);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start      <= 1'b0;
         burst_left = int'($urandom_range(0, 20));
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic drain;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic gaes_pkg::req_type random_layout(input int v);
      gaes_pkg::req_type r;
      r.command           = gaes_pkg::CMD_SET;
      r.source_vertex     = 10'(v);
      r.target_vertex     = 10'($urandom_range(0, 1023));
      r.out_list_base     = 13'($urandom_range(0, 1) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, 8191));
      r.in_list_base      = 13'($urandom_range(0, 1) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, 8191));
      r.out_list_capacity = 14'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383)
                                                             : $urandom_range(0, 10));
      r.in_list_capacity  = 14'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383)
                                                             : $urandom_range(0, 10));
      return r;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      gaes_pkg::rsp_type e;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            report("result transfer with nothing expected");
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_item.status !== e.status)
               report($sformatf("status %0d, want %0d", rsp_item.status, e.status));
            if (rsp_item.source_out_degree !== e.source_out_degree)
               report($sformatf("source_out_degree %0d, want %0d",
                                rsp_item.source_out_degree, e.source_out_degree));
            if (rsp_item.target_in_degree !== e.target_in_degree)
               report($sformatf("target_in_degree %0d, want %0d",
                                rsp_item.target_in_degree, e.target_in_degree));
         end
      end
   end

   initial begin
      gaes_pkg::req_type r;
      gaes_pkg::rsp_type none;
      int                n, k, s, d;
      none = '0;
      for (k = 0; k < VN; k++) begin
         out_deg[k]  = 0;
         in_deg[k]   = 0;
         laid_out[k] = 1'b0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      add_row(gaes_pkg::CMD_SET,    0,    1023, 0,    0,    16383, 16383, 1,
              gaes_pkg::ST_OK,        0, 0);
      add_row(gaes_pkg::CMD_SET,    1023, 1023, 8191, 8191, 2,     1,     1,
              gaes_pkg::ST_OK,        0, 0);
      add_row(gaes_pkg::CMD_INSERT, 0,    1023, 8191, 8191, 16383, 16383, 1,
              gaes_pkg::ST_OK,        1, 1);
      add_row(gaes_pkg::CMD_INSERT, 0,    1023, 0,    0,    0,     0,     1,
              gaes_pkg::ST_FULL,      1, 1);
      add_row(gaes_pkg::CMD_DELETE, 1023, 0,    0,    0,    0,     0,     1,
              gaes_pkg::ST_NOT_FOUND, 0, 0);
      add_row(gaes_pkg::CMD_NONE,   0,    1023, 8191, 8191, 16383, 16383, 1,
              gaes_pkg::ST_OK,        1, 1);
      add_row(gaes_pkg::CMD_DELETE, 0,    1023, 0,    0,    0,     0,     1,
              gaes_pkg::ST_OK,        0, 0);
      add_row(gaes_pkg::CMD_DELETE, 0,    1023, 0,    0,    0,     0,     1,
              gaes_pkg::ST_NOT_FOUND, 0, 0);
      add_row(gaes_pkg::CMD_SET,    5,    682,  8190, 8190, 4,     4,     1,
              gaes_pkg::ST_OK,        0, 0);
      add_row(gaes_pkg::CMD_INSERT, 5,    5,    0,    0,    0,     0,     1,
              gaes_pkg::ST_OK,        1, 1);
      add_row(gaes_pkg::CMD_INSERT, 5,    5,    0,    0,    0,     0,     1,
              gaes_pkg::ST_OK,        2, 2);
      add_row(gaes_pkg::CMD_INSERT, 5,    0,    0,    0,    0,     0,     1,
              gaes_pkg::ST_OK,        3, 1);
      add_row(gaes_pkg::CMD_INSERT, 5,    5,    0,    0,    0,     0,     0,
              gaes_pkg::ST_OK,        0, 0);
      add_row(gaes_pkg::CMD_INSERT, 5,    0,    0,    0,    0,     0,     1,
              gaes_pkg::ST_FULL,      4, 1);
      add_row(gaes_pkg::CMD_DELETE, 5,    5,    0,    0,    0,     0,     0,
              gaes_pkg::ST_OK,        0, 0);
      add_row(gaes_pkg::CMD_DELETE, 5,    0,    0,    0,    0,     0,     1,
              gaes_pkg::ST_OK,        2, 0);
      add_row(gaes_pkg::CMD_DELETE, 5,    5,    0,    0,    0,     0,     0,
              gaes_pkg::ST_OK,        0, 0);
      add_row(gaes_pkg::CMD_SET,    1023, 0,    4096, 5000, 0,     0,     1,
              gaes_pkg::ST_OK,        0, 0);
      add_row(gaes_pkg::CMD_INSERT, 0,    1023, 0,    0,    0,     0,     1,
              gaes_pkg::ST_FULL,      0, 0);
      add_row(gaes_pkg::CMD_INSERT, 1023, 0,    0,    0,    0,     0,     1,
              gaes_pkg::ST_FULL,      0, 0);
      add_row(gaes_pkg::CMD_SET,    0,    0,    8191, 0,    8192,  8193,  1,
              gaes_pkg::ST_OK,        0, 0);

      foreach (rows[i]) send(rows[i].cmd, rows[i].typed, rows[i].want);
      start <= 1'b0;
      drain();

      for (k = 0; k < POOL_SIZE; k++) begin
         pool[k] = int'($urandom_range(0, 1023));
         send(random_layout(pool[k]), 1'b0, none);
      end

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) begin
            start <= 1'b0;
            drain();
         end
         k = int'($urandom_range(0, 99));
         s = pool[$urandom_range(0, POOL_SIZE - 1)];
         d = pool[$urandom_range(0, POOL_SIZE - 1)];
         r.source_vertex     = 10'(s);
         r.target_vertex     = 10'(d);
         r.out_list_base     = 13'($urandom_range(0, 8191));
         r.in_list_base      = 13'($urandom_range(0, 8191));
         r.out_list_capacity = 14'($urandom_range(0, 16383));
         r.in_list_capacity  = 14'($urandom_range(0, 16383));
         if (k < 5) begin
            s = int'($urandom_range(0, POOL_SIZE - 1));
            pool[s] = int'($urandom_range(0, 1023));
            r = random_layout(pool[s]);
         end else if (k < 55) begin
            r.command = gaes_pkg::CMD_INSERT;
         end else if (k < 96) begin
            r.command = gaes_pkg::CMD_DELETE;
         end else begin
            r.command = gaes_pkg::CMD_NONE;
         end
         send(r, 1'b0, none);
      end

      start <= 1'b0;
      drain();
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
